@@ design/active_pair_prediction_table_assert.svh @@
// assertion macros for the pair prediction table
// used by the top level only; expects a signal named clk and rst in scope
`ifndef ACTIVE_PAIR_PREDICTION_TABLE_ASSERT_SVH
`define ACTIVE_PAIR_PREDICTION_TABLE_ASSERT_SVH

// same-cycle implication
`define APT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define APT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/apt_pkg.sv @@
// shared types and codes of the pair prediction table
// no dependencies
package apt_pkg;

  localparam logic [15:0] NO_REG = 16'hFFFF;

  // operation codes
  localparam logic [2:0] FN_INSERT = 3'd0;
  localparam logic [2:0] FN_LOOKUP = 3'd1;
  localparam logic [2:0] FN_RM_PC  = 3'd2;
  localparam logic [2:0] FN_RM_UOP = 3'd3;
  localparam logic [2:0] FN_REOPEN = 3'd4;
  localparam logic [2:0] FN_SETREG = 3'd5;
  localparam logic [2:0] FN_TAKE   = 3'd6;
  localparam logic [2:0] FN_CLEAN  = 3'd7;

  // result kinds
  localparam logic [2:0] KD_REPLY  = 3'd0;
  localparam logic [2:0] KD_INVAL  = 3'd1;
  localparam logic [2:0] KD_FREE   = 3'd2;
  localparam logic [2:0] KD_FORGET = 3'd3;
  localparam logic [2:0] KD_INSERT = 3'd4;

  // configuration register indexes
  localparam logic CFG_MATCH_NEWEST = 1'b0;
  localparam logic CFG_FUSION_DIST  = 1'b1;

  typedef struct packed {
    logic [2:0]  func;
    logic [63:0] second_pc;
    logic [63:0] first_pc;
    logic [63:0] first_addr;
    logic [31:0] first_uop;
    logic [6:0]  first_size;
    logic [6:0]  second_size;
    logic [63:0] second_addr;
    logic [7:0]  slot_index;
    logic [15:0] reg_id;
    logic [63:0] now_uop;
  } apt_in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic        found;
    logic [63:0] out_first_pc;
    logic [63:0] out_first_addr;
    logic [31:0] out_uop;
    logic [6:0]  out_first_size;
    logic [6:0]  out_second_size;
    logic [63:0] out_second_addr;
    logic [7:0]  out_slot;
    logic [15:0] out_reg;
    logic        last;
  } apt_out_t;

  // controller to datapath
  typedef struct packed {
    logic       load_in;
    logic       scan_clear;
    logic       scan_step;
    logic       apply;
    logic       emit;
    logic [2:0] emit_kind;
    logic       emit_found;
    logic       emit_last;
    logic       emit_entry;
  } apt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] func;
    logic       cand;
    logic       best_found;
    logic [3:0] note_mask;
    logic       out_free;
  } apt_status_t;

endpackage

@@ design/apt_datapath.sv @@
// entry storage, scan compare, config registers and result register
// depends on apt_pkg
module apt_datapath import apt_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_data,
  input  apt_in_t           in_data,
  input  logic              out_ready,
  output logic              out_valid,
  output apt_out_t          out_data,
  input  apt_cmd_t          cmd,
  input  logic [IDX_W-1:0]  scan_idx,
  input  logic [IDX_W-1:0]  sel_idx,
  output logic [IDX_W-1:0]  best_idx,
  output apt_status_t       status
);

  logic        match_newest;
  logic [31:0] fusion_distance;
  apt_in_t     req;

  logic        e_valid   [TABLE_DEPTH];
  logic        e_matched [TABLE_DEPTH];
  logic [63:0] e_spc     [TABLE_DEPTH];
  logic [63:0] e_fpc     [TABLE_DEPTH];
  logic [63:0] e_faddr   [TABLE_DEPTH];
  logic [31:0] e_uop     [TABLE_DEPTH];
  logic [13:0] e_sizes   [TABLE_DEPTH];
  logic [63:0] e_saddr   [TABLE_DEPTH];
  logic [7:0]  e_slot    [TABLE_DEPTH];
  logic [15:0] e_reg     [TABLE_DEPTH];
  logic [63:0] e_age     [TABLE_DEPTH];
  logic [63:0] age_counter;

  logic        best_found;
  logic [63:0] best_age;

  logic        s_valid, s_matched, pc_ok, pc_eq, uop_eq, stale, cand, better;
  logic [63:0] s_age, uop_gap;
  logic        is_rm;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      match_newest    <= 1'b0;
      fusion_distance <= 32'd64;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MATCH_NEWEST: match_newest <= cfg_data[0];
        CFG_FUSION_DIST:  fusion_distance <= cfg_data;
        default: ;
      endcase
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) req <= in_data;
  end

  // compare of the scanned entry
  always_comb begin
    s_valid   = e_valid[scan_idx];
    s_matched = e_matched[scan_idx];
    s_age     = e_age[scan_idx];
    pc_ok     = req.second_pc != 64'd0;
    pc_eq     = e_spc[scan_idx] == req.second_pc;
    uop_eq    = e_uop[scan_idx] == req.first_uop;
    uop_gap   = req.now_uop - {32'd0, e_uop[scan_idx]};
    stale     = uop_gap > {32'd0, fusion_distance};
    case (req.func)
      FN_INSERT: cand = !s_valid && pc_ok;
      FN_LOOKUP: cand = s_valid && pc_ok && pc_eq && !s_matched;
      FN_RM_PC:  cand = s_valid && pc_ok && pc_eq && uop_eq;
      FN_RM_UOP: cand = s_valid && uop_eq;
      FN_REOPEN: cand = s_valid && pc_ok && pc_eq && uop_eq && s_matched;
      FN_SETREG: cand = s_valid && uop_eq && (req.reg_id != NO_REG);
      FN_TAKE:   cand = s_valid && pc_ok && pc_eq && uop_eq && (e_reg[scan_idx] != NO_REG);
      FN_CLEAN:  cand = s_valid && !s_matched && stale;
      default:   cand = 1'b0;
    endcase
    case (req.func)
      FN_INSERT: better = !best_found;
      FN_LOOKUP: better = !best_found ||
                          (match_newest ? (s_age > best_age) : (s_age < best_age));
      default:   better = !best_found || (s_age > best_age);
    endcase
  end

  // running best of the scan
  always_ff @(posedge clk) begin
    if (rst || cmd.scan_clear) begin
      best_found <= 1'b0;
    end else if (cmd.scan_step && cand && better) begin
      best_found <= 1'b1;
      best_idx   <= scan_idx;
      best_age   <= s_age;
    end
  end

  // notifications owed by the selected entry
  always_comb begin
    is_rm = (req.func == FN_RM_PC) || (req.func == FN_RM_UOP) ||
            (req.func == FN_TAKE) || (req.func == FN_CLEAN);
    status.func       = req.func;
    status.cand       = cand;
    status.best_found = best_found;
    status.note_mask[0] = is_rm && !e_matched[sel_idx];
    status.note_mask[1] = is_rm && (e_reg[sel_idx] != NO_REG) && (req.func != FN_TAKE);
    status.note_mask[2] = is_rm && (req.func != FN_TAKE);
    status.note_mask[3] = req.func == FN_REOPEN;
    status.out_free   = !out_valid || out_ready;
  end

  // entry state flags
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        e_valid[i]   <= 1'b0;
        e_matched[i] <= 1'b0;
      end
      age_counter <= 64'd0;
    end else if (cmd.apply) begin
      case (req.func)
        FN_INSERT: begin
          e_valid[sel_idx]   <= 1'b1;
          e_matched[sel_idx] <= 1'b0;
          age_counter        <= age_counter + 64'd1;
        end
        FN_LOOKUP: e_matched[sel_idx] <= 1'b1;
        FN_REOPEN: e_matched[sel_idx] <= 1'b0;
        FN_SETREG: ;
        default:   e_valid[sel_idx] <= 1'b0;
      endcase
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      if (req.func == FN_INSERT) begin
        e_spc[sel_idx]   <= req.second_pc;
        e_fpc[sel_idx]   <= req.first_pc;
        e_faddr[sel_idx] <= req.first_addr;
        e_uop[sel_idx]   <= req.first_uop;
        e_sizes[sel_idx] <= {req.second_size, req.first_size};
        e_saddr[sel_idx] <= req.second_addr;
        e_slot[sel_idx]  <= req.slot_index;
        e_reg[sel_idx]   <= NO_REG;
        e_age[sel_idx]   <= age_counter + 64'd1;
      end else if (req.func == FN_SETREG) begin
        e_reg[sel_idx] <= req.reg_id;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.kind  <= cmd.emit_kind;
      out_data.found <= cmd.emit_found;
      out_data.last  <= cmd.emit_last;
      if (cmd.emit_entry) begin
        out_data.out_first_pc    <= e_fpc[sel_idx];
        out_data.out_first_addr  <= e_faddr[sel_idx];
        out_data.out_uop         <= e_uop[sel_idx];
        out_data.out_first_size  <= e_sizes[sel_idx][6:0];
        out_data.out_second_size <= e_sizes[sel_idx][13:7];
        out_data.out_second_addr <= e_saddr[sel_idx];
        out_data.out_slot        <= e_slot[sel_idx];
        // a taken register is already cleared in its notifications
        out_data.out_reg <= (cmd.emit_kind != KD_REPLY && req.func == FN_TAKE) ?
                            NO_REG : e_reg[sel_idx];
      end else begin
        out_data.out_first_pc    <= 64'd0;
        out_data.out_first_addr  <= 64'd0;
        out_data.out_uop         <= 32'd0;
        out_data.out_first_size  <= 7'd0;
        out_data.out_second_size <= 7'd0;
        out_data.out_second_addr <= 64'd0;
        out_data.out_slot        <= 8'd0;
        out_data.out_reg         <= NO_REG;
      end
    end
  end

endmodule

@@ design/apt_ctrl.sv @@
// sequencer: scan, update, notification beats and reply
// depends on apt_pkg
module apt_ctrl import apt_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  apt_status_t       status,
  input  logic [IDX_W-1:0]  best_idx,
  output apt_cmd_t          cmd,
  output logic [IDX_W-1:0]  scan_idx,
  output logic [IDX_W-1:0]  sel_idx
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_APPLY, S_NOTE, S_REPLY
  } state_t;

  state_t     state;
  logic [3:0] mask;
  logic       any;
  logic       hit;
  logic [2:0] note_kind;
  logic [3:0] note_bit;

  // lowest pending notification first
  always_comb begin
    if (mask[0]) begin
      note_kind = KD_INVAL;  note_bit = 4'b0001;
    end else if (mask[1]) begin
      note_kind = KD_FREE;   note_bit = 4'b0010;
    end else if (mask[2]) begin
      note_kind = KD_FORGET; note_bit = 4'b0100;
    end else begin
      note_kind = KD_INSERT; note_bit = 4'b1000;
    end
  end

  assign in_ready = state == S_IDLE;

  // commands decoded from state
  always_comb begin
    cmd = '0;
    cmd.load_in    = in_valid && in_ready;
    cmd.scan_clear = cmd.load_in;
    case (state)
      S_SCAN:  cmd.scan_step = 1'b1;
      S_APPLY: cmd.apply = 1'b1;
      S_NOTE: begin
        cmd.emit       = (mask != 4'd0) && status.out_free;
        cmd.emit_kind  = note_kind;
        cmd.emit_entry = 1'b1;
      end
      S_REPLY: begin
        cmd.emit       = status.out_free;
        cmd.emit_kind  = KD_REPLY;
        cmd.emit_found = (status.func == FN_CLEAN) ? any : hit;
        cmd.emit_last  = 1'b1;
        cmd.emit_entry = hit && (status.func != FN_CLEAN);
      end
      default: ;
    endcase
  end

  // state and sequencing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      scan_idx <= '0;
      sel_idx  <= '0;
      mask     <= 4'd0;
      any      <= 1'b0;
      hit      <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state    <= S_SCAN;
            scan_idx <= '0;
            any      <= 1'b0;
            hit      <= 1'b0;
          end
        end
        S_SCAN: begin
          if (status.func == FN_CLEAN && status.cand) begin
            sel_idx <= scan_idx;
            any     <= 1'b1;
            state   <= S_APPLY;
          end else if (scan_idx == LAST_IDX) begin
            state <= S_DECIDE;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        S_DECIDE: begin
          if (status.func != FN_CLEAN && status.best_found) begin
            sel_idx <= best_idx;
            hit     <= 1'b1;
            state   <= S_APPLY;
          end else begin
            state <= S_REPLY;
          end
        end
        S_APPLY: begin
          mask  <= status.note_mask;
          state <= S_NOTE;
        end
        S_NOTE: begin
          if (mask == 4'd0) begin
            if (status.func != FN_CLEAN) begin
              state <= S_REPLY;
            end else if (scan_idx == LAST_IDX) begin
              state <= S_DECIDE;
            end else begin
              scan_idx <= scan_idx + 1'b1;
              state    <= S_SCAN;
            end
          end else if (status.out_free) begin
            mask <= mask & ~note_bit;
          end
        end
        S_REPLY: begin
          if (status.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ design/active_pair_prediction_table.sv @@
// channel    | handshake            | payload
// cfg        | cfg_valid/cfg_ready  | cfg_index, cfg_data
// in         | in_valid/in_ready    | in_data (apt_in_t)
// out        | out_valid/out_ready  | out_data (apt_out_t)
// an item with no entry found passes through accept, the entry scan, a
// decide step and the reply; the scan checks one slot a cycle, pausing at
// each entry a cleanup removes. a hit adds an apply step and notification
// beats, as does each entry a cleanup removes. results stall in place while
// out_ready is low. reset empties the table and restores the config defaults.
// top level of the pair prediction table; depends on apt_pkg, apt_ctrl,
// apt_datapath and the assertion header
module active_pair_prediction_table import apt_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  apt_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output apt_out_t    out_data
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  apt_cmd_t         cmd;
  apt_status_t      status;
  logic [IDX_W-1:0] scan_idx;
  logic [IDX_W-1:0] sel_idx;
  logic [IDX_W-1:0] best_idx;

  assign cfg_ready = 1'b1;

  apt_ctrl #(.TABLE_DEPTH(TABLE_DEPTH), .IDX_W(IDX_W)) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .status(status), .best_idx(best_idx), .cmd(cmd),
    .scan_idx(scan_idx), .sel_idx(sel_idx)
  );

  apt_datapath #(.TABLE_DEPTH(TABLE_DEPTH), .IDX_W(IDX_W)) u_dp (
    .clk(clk), .rst(rst), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_data(in_data), .out_ready(out_ready),
    .out_valid(out_valid), .out_data(out_data), .cmd(cmd),
    .scan_idx(scan_idx), .sel_idx(sel_idx), .best_idx(best_idx), .status(status)
  );

`include "active_pair_prediction_table_assert.svh"

  // one item in flight at a time
  `APT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted twice")
  // the closing beat is always the reply
  `APT_ASSERT_NOW(a_last_is_reply, out_valid && out_data.last, out_data.kind == KD_REPLY, "last on a notification")
  // notification beats carry no success and never close the item
  `APT_ASSERT_NOW(a_note_clean, out_valid && out_data.kind != KD_REPLY, !out_data.found && !out_data.last, "bad notification flags")

endmodule
